>>> hw/rtl/typed_integer_alu_unit_assert.svh
// Assertion macros used by the typed integer ALU unit.
`ifndef TYPED_INTEGER_ALU_UNIT_ASSERT_SVH
`define TYPED_INTEGER_ALU_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TIA_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("check failed");

// An implication checked in the same cycle.
`define TIA_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

// An implication whose consequent is checked in the next cycle.
`define TIA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

>>> hw/rtl/tia_pkg.sv
// ----------------------------------------------------------------------------
// tia_pkg
// Shared codes, types and helper functions of the typed integer ALU.
// ----------------------------------------------------------------------------
package tia_pkg;

   // Operation codes.
   localparam logic [4:0] FN_ADD = 5'd0;
   localparam logic [4:0] FN_SUB = 5'd1;
   localparam logic [4:0] FN_MUL = 5'd2;
   localparam logic [4:0] FN_DIV = 5'd3;
   localparam logic [4:0] FN_MOD = 5'd4;
   localparam logic [4:0] FN_POW = 5'd5;
   localparam logic [4:0] FN_LT  = 5'd6;
   localparam logic [4:0] FN_GT  = 5'd7;
   localparam logic [4:0] FN_LE  = 5'd8;
   localparam logic [4:0] FN_GE  = 5'd9;
   localparam logic [4:0] FN_EQ  = 5'd10;
   localparam logic [4:0] FN_NE  = 5'd11;
   localparam logic [4:0] FN_AND = 5'd12;
   localparam logic [4:0] FN_OR  = 5'd13;
   localparam logic [4:0] FN_NEG = 5'd14;
   localparam logic [4:0] FN_INC = 5'd15;
   localparam logic [4:0] FN_DEC = 5'd16;
   localparam logic [4:0] FN_NOT = 5'd17;

   // Type codes.
   localparam logic [3:0] TY_NULL = 4'd0;
   localparam logic [3:0] TY_BOOL = 4'd1;
   localparam logic [3:0] TY_U8   = 4'd2;
   localparam logic [3:0] TY_U16  = 4'd3;
   localparam logic [3:0] TY_U32  = 4'd4;
   localparam logic [3:0] TY_U64  = 4'd5;
   localparam logic [3:0] TY_I8   = 4'd6;
   localparam logic [3:0] TY_I16  = 4'd7;
   localparam logic [3:0] TY_I32  = 4'd8;
   localparam logic [3:0] TY_I64  = 4'd9;

   // Error codes.
   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_TYPES   = 2'd1;
   localparam logic [1:0] ERR_OPTYPE  = 2'd2;
   localparam logic [1:0] ERR_DIVZERO = 2'd3;

   // Request to the shared multiplier.
   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } mul_req_type;

   // Status and product from the shared multiplier.
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic is_int(logic [3:0] t);
      return (t >= TY_U8) && (t <= TY_I64);
   endfunction

   function automatic logic is_signed(logic [3:0] t);
      return (t >= TY_I8) && (t <= TY_I64);
   endfunction

   // Canonical 64-bit form of a value of type t.
   function automatic logic [63:0] canon(logic [3:0] t, logic [63:0] v);
      logic [63:0] r;
      logic        sg;
      sg = is_signed(t);
      case (t)
         TY_NULL:      r = 64'd0;
         TY_BOOL:      r = {63'd0, v[0]};
         TY_U8, TY_I8: r = {{56{sg & v[7]}}, v[7:0]};
         TY_U16, TY_I16: r = {{48{sg & v[15]}}, v[15:0]};
         TY_U32, TY_I32: r = {{32{sg & v[31]}}, v[31:0]};
         default:      r = v;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/typed_integer_alu_unit.sv
// Throughput: one word at a time; the next word is taken once the block is back in idle.
// The divider retires one quotient bit a cycle; each multiply runs on the
// shared 32 by 32 multiplier. Synchronous active-high reset clears all control state.
// ----------------------------------------------------------------------------
// typed_integer_alu_unit
// Typed scalar ALU: decode, then divider or shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
`include "typed_integer_alu_unit_assert.svh"

module typed_integer_alu_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // operand_a[63:0], operand_b[127:64]
   input  logic [12:0]   req_tuser,   // func[4:0], type_a[8:5], type_b[12:9]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // result_value[63:0]
   output logic [7:0]    rsp_tuser    // result_type[3:0], error_code[5:4], zero
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_DIV, ST_MUL, ST_POW_CHK, ST_POW_R, ST_POW_B, ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  func_ff, func_in;
   logic [3:0]  ta_ff, ta_in, tb_ff, tb_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        na_ff, na_in, nb_ff, nb_in;
   logic [63:0] res_ff, res_in;
   logic [3:0]  rty_ff, rty_in;
   logic [1:0]  rerr_ff, rerr_in;
   logic        go_ff, go_in;
   logic [63:0] mx_ff, mx_in, my_ff, my_in;
   logic        ov_ff, ov_in;
   logic [63:0] ov_val_ff, ov_val_in;
   logic [3:0]  ov_ty_ff, ov_ty_in;
   logic [1:0]  ov_err_ff, ov_err_in;

   tia_pkg::mul_req_type mul_req;
   tia_pkg::mul_rsp_type mul_rsp;

   logic [63:0] ca, cb, flip;
   logic        lt, gt, eq, sg, cmp;
   logic [64:0] rem_sh;
   logic        out_free;
   logic        out_err, out_bool;

   tia_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign mul_req.start = go_ff;
   assign mul_req.op_a  = mx_ff;
   assign mul_req.op_b  = my_ff;

   // Canonical operands and comparisons of the held word.
   always_comb begin
      ca   = tia_pkg::canon(ta_ff, a_ff);
      cb   = tia_pkg::canon(ta_ff, b_ff);
      sg   = tia_pkg::is_signed(ta_ff);
      flip = {sg, 63'd0};
      lt   = (ca ^ flip) < (cb ^ flip);
      gt   = (cb ^ flip) < (ca ^ flip);
      eq   = (ca == cb);
      case (func_ff)
         tia_pkg::FN_LT: cmp = lt;
         tia_pkg::FN_GT: cmp = gt;
         tia_pkg::FN_LE: cmp = !gt;
         tia_pkg::FN_GE: cmp = !lt;
         tia_pkg::FN_EQ: cmp = eq;
         default:        cmp = !eq;
      endcase
      rem_sh = {rem_ff, quo_ff[63]};
   end

   assign out_free = !ov_ff || rsp_tready;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      ta_in     = ta_ff;
      tb_in     = tb_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      res_in    = res_ff;
      rty_in    = rty_ff;
      rerr_in   = rerr_ff;
      go_in     = 1'b0;
      mx_in     = mx_ff;
      my_in     = my_ff;
      ov_in     = ov_ff && !rsp_tready;
      ov_val_in = ov_val_ff;
      ov_ty_in  = ov_ty_ff;
      ov_err_in = ov_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser[4:0];
               ta_in    = req_tuser[8:5];
               tb_in    = req_tuser[12:9];
               a_in     = req_tdata[63:0];
               b_in     = req_tdata[127:64];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Decode, and the operations that are computed directly in this state.
            state_in = ST_DONE;
            rerr_in  = tia_pkg::ERR_OK;
            rty_in   = ta_ff;
            res_in   = 64'd0;
            if (func_ff > tia_pkg::FN_NOT || ta_ff > tia_pkg::TY_I64) begin
               rerr_in = (func_ff <= tia_pkg::FN_OR && tb_ff != ta_ff) ?
                         tia_pkg::ERR_TYPES : tia_pkg::ERR_OPTYPE;
            end else if (func_ff >= tia_pkg::FN_NEG) begin
               case (func_ff)
                  tia_pkg::FN_NEG: begin
                     if (!sg) rerr_in = tia_pkg::ERR_OPTYPE;
                     res_in = tia_pkg::canon(ta_ff, 64'd0 - ca);
                  end
                  tia_pkg::FN_INC: begin
                     if (!tia_pkg::is_int(ta_ff)) rerr_in = tia_pkg::ERR_OPTYPE;
                     res_in = tia_pkg::canon(ta_ff, ca + 64'd1);
                  end
                  tia_pkg::FN_DEC: begin
                     if (!tia_pkg::is_int(ta_ff)) rerr_in = tia_pkg::ERR_OPTYPE;
                     res_in = tia_pkg::canon(ta_ff, ca - 64'd1);
                  end
                  default: begin
                     if (ta_ff != tia_pkg::TY_BOOL) rerr_in = tia_pkg::ERR_OPTYPE;
                     res_in = {63'd0, ~ca[0]};
                  end
               endcase
            end else if (tb_ff != ta_ff) begin
               rerr_in = tia_pkg::ERR_TYPES;
            end else if (func_ff >= tia_pkg::FN_LT && func_ff <= tia_pkg::FN_NE) begin
               rty_in = tia_pkg::TY_BOOL;
               res_in = {63'd0, cmp};
            end else if (func_ff == tia_pkg::FN_AND || func_ff == tia_pkg::FN_OR) begin
               if (ta_ff != tia_pkg::TY_BOOL) rerr_in = tia_pkg::ERR_OPTYPE;
               res_in = (func_ff == tia_pkg::FN_AND) ? (ca & cb) : (ca | cb);
            end else if (!tia_pkg::is_int(ta_ff)) begin
               rerr_in = tia_pkg::ERR_OPTYPE;
            end else begin
               case (func_ff)
                  tia_pkg::FN_ADD: res_in = tia_pkg::canon(ta_ff, ca + cb);
                  tia_pkg::FN_SUB: res_in = tia_pkg::canon(ta_ff, ca - cb);
                  tia_pkg::FN_MUL: begin
                     mx_in    = ca;
                     my_in    = cb;
                     go_in    = 1'b1;
                     state_in = ST_MUL;
                  end
                  tia_pkg::FN_DIV, tia_pkg::FN_MOD: begin
                     if (cb == 64'd0) begin
                        rerr_in = tia_pkg::ERR_DIVZERO;
                     end else begin
                        na_in    = sg & ca[63];
                        nb_in    = sg & cb[63];
                        quo_in   = (sg & ca[63]) ? (64'd0 - ca) : ca;
                        b_in     = (sg & cb[63]) ? (64'd0 - cb) : cb;
                        rem_in   = 64'd0;
                        cnt_in   = 6'd0;
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                     // Power: base in a_ff, exponent in b_ff, product in res_ff.
                     a_in     = ca;
                     b_in     = (sg & cb[63]) ? 64'd0 : cb;
                     res_in   = 64'd1;
                     state_in = ST_POW_CHK;
                  end
               endcase
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit a cycle.
            if (rem_sh >= {1'b0, b_ff}) begin
               rem_in = 64'(rem_sh - {1'b0, b_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_DONE;
               rerr_in  = tia_pkg::ERR_OK;
               rty_in   = ta_ff;
               if (func_ff == tia_pkg::FN_DIV) begin
                  res_in = tia_pkg::canon(ta_ff,
                           (na_ff != nb_ff) ? (64'd0 - quo_in) : quo_in);
               end else begin
                  res_in = tia_pkg::canon(ta_ff, na_ff ? (64'd0 - rem_in) : rem_in);
               end
            end
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               res_in   = tia_pkg::canon(ta_ff, mul_rsp.product);
               rerr_in  = tia_pkg::ERR_OK;
               rty_in   = ta_ff;
               state_in = ST_DONE;
            end
         end
         ST_POW_CHK: begin
            // Square and multiply, lowest exponent bit first.
            if (b_ff == 64'd0) begin
               res_in   = tia_pkg::canon(ta_ff, res_ff);
               rerr_in  = tia_pkg::ERR_OK;
               rty_in   = ta_ff;
               state_in = ST_DONE;
            end else if (b_ff[0]) begin
               mx_in    = res_ff;
               my_in    = a_ff;
               go_in    = 1'b1;
               state_in = ST_POW_R;
            end else begin
               mx_in    = a_ff;
               my_in    = a_ff;
               go_in    = 1'b1;
               state_in = ST_POW_B;
            end
         end
         ST_POW_R: begin
            if (mul_rsp.done) begin
               res_in   = mul_rsp.product;
               mx_in    = a_ff;
               my_in    = a_ff;
               go_in    = 1'b1;
               state_in = ST_POW_B;
            end
         end
         ST_POW_B: begin
            if (mul_rsp.done) begin
               a_in     = mul_rsp.product;
               b_in     = {1'b0, b_ff[63:1]};
               state_in = ST_POW_CHK;
            end
         end
         ST_DONE: begin
            // Hand the word to the output register once it is free.
            if (out_free) begin
               ov_in     = 1'b1;
               ov_val_in = (rerr_ff == tia_pkg::ERR_OK) ? res_ff : 64'd0;
               ov_ty_in  = (rerr_ff == tia_pkg::ERR_OK) ? rty_ff : tia_pkg::TY_NULL;
               ov_err_in = rerr_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         ov_ff    <= ov_in;
      end
      func_ff   <= func_in;
      ta_ff     <= ta_in;
      tb_ff     <= tb_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      res_ff    <= res_in;
      rty_ff    <= rty_in;
      rerr_ff   <= rerr_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      ov_val_ff <= ov_val_in;
      ov_ty_ff  <= ov_ty_in;
      ov_err_ff <= ov_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ov_val_ff;
   assign rsp_tuser  = {2'd0, ov_err_ff, ov_ty_ff};

   // Kinds of the word held in the output register.
   assign out_err  = ov_ff && (ov_err_ff != tia_pkg::ERR_OK);
   assign out_bool = ov_ff && (ov_err_ff == tia_pkg::ERR_OK) && (ov_ty_ff == tia_pkg::TY_BOOL);

   // An errored word carries a zero value of type null.
   `TIA_ASSERT_IMPLY(a_err_zero, out_err, ov_val_ff == 64'd0 && ov_ty_ff == tia_pkg::TY_NULL)
   // A good bool result is 0 or 1.
   `TIA_ASSERT_IMPLY(a_bool_bit, out_bool, ov_val_ff[63:1] == 63'd0)
   // The multiplier is only started while it is idle.
   `TIA_ASSERT_IMPLY(a_mul_idle, go_ff, !mul_rsp.busy)
   // An accepted word blocks the input in the following cycle.
   `TIA_ASSERT_NEXT(a_busy_after, req_tvalid && req_tready, !req_tready)

endmodule

>>> hw/rtl/tia_mul64.sv
// ----------------------------------------------------------------------------
// tia_mul64
// Low 64 bits of a 64 by 64 product from one shared 32 by 32 multiplier.
// ----------------------------------------------------------------------------
module tia_mul64 (
   input  logic                 clock,
   input  logic                 reset,
   input  tia_pkg::mul_req_type mul_req,
   output tia_pkg::mul_rsp_type mul_rsp
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_LL, PH_LH, PH_HL, PH_SUM
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] mult_ff, mult_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mx, my;

   // Operand selection for the shared multiplier, one partial product a cycle.
   always_comb begin
      mx = a_ff[31:0];
      my = b_ff[31:0];
      case (phase_ff)
         PH_LH:   my = b_ff[63:32];
         PH_HL:   mx = a_ff[63:32];
         default: ;
      endcase
      mult_in = 64'(mx) * 64'(my);
   end

   // Sequencer and accumulation.
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (mul_req.start) begin
               a_in     = mul_req.op_a;
               b_in     = mul_req.op_b;
               phase_in = PH_LL;
            end
         end
         PH_LL: phase_in = PH_LH;
         PH_LH: begin
            acc_in   = mult_ff;
            phase_in = PH_HL;
         end
         PH_HL: begin
            acc_in   = acc_ff + {mult_ff[31:0], 32'd0};
            phase_in = PH_SUM;
         end
         PH_SUM: begin
            acc_in   = acc_ff + {mult_ff[31:0], 32'd0};
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      mult_ff <= mult_in;
      acc_ff  <= acc_in;
   end

   assign mul_rsp.busy    = (phase_ff != PH_IDLE);
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule
